// ===== rtl/rest_triangle_inverse_assert.svh =====
// assertion macros shared by the rest triangle inverse rtl
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef REST_TRIANGLE_INVERSE_ASSERT_SVH
`define REST_TRIANGLE_INVERSE_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define RTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
// shared constants and types for the rest triangle inverse pipeline
// no dependencies
package rti_pkg;

    localparam int VERTEX_INDEX_BITS_DEF = 20;
    localparam int COORD_BITS_DEF        = 24;

    // fraction bits added to the numerator before division
    localparam int Q_SHIFT   = 28;
    localparam int INV_W     = 32;
    localparam int LANES     = 4;

    localparam int MIN_DET_W  = 41;
    localparam int MAT_IN_W   = 48;
    localparam int MAT_OUT_W  = 47;
    localparam int CFG_DATA_W = 47;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DET      = 1'b0,
        CFG_FALLBACK_MAT = 1'b1
    } t_cfg_idx;

    localparam logic [MIN_DET_W-1:0] MIN_DET_RST  = 41'd17;
    localparam logic [MAT_OUT_W-1:0] FALLBACK_RST = 47'd65536000000;

    // pipeline advance enable and the valid bit entering a unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

// ===== rtl/rti_front.sv =====
// front end: origin selection, edge matrix, determinant and clamp (four stages)
// depends on rti_pkg and rest_triangle_inverse_assert.svh
`include "rest_triangle_inverse_assert.svh"
module rti_front #(
    parameter int IDX_W  = rti_pkg::VERTEX_INDEX_BITS_DEF,
    parameter int CB     = rti_pkg::COORD_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rti_pkg::t_stage_ctl             i_ctl,
    input  logic [IDX_W-1:0]                i_idx [3],
    input  logic signed [CB-1:0]            i_px [3],
    input  logic signed [CB-1:0]            i_py [3],
    input  logic [rti_pkg::MIN_DET_W-1:0]   i_min_det,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [IDX_W-1:0]                o_idx [3],
    output logic [CB:0]                     o_num_mag [rti_pkg::LANES],
    output logic                            o_num_neg [rti_pkg::LANES],
    output logic [2*CB+2:0]                 o_dmag,
    output logic [SIDE_W-1:0]               o_side
);
    import rti_pkg::*;

    localparam int DW   = CB + 1;
    localparam int PW   = 2 * CB + 2;
    localparam int DETW = 2 * CB + 3;

    function automatic logic lower_left(input logic signed [DW-1:0] cs,
                                        input logic signed [DW-1:0] bs,
                                        input logic signed [CB-1:0] cy,
                                        input logic signed [CB-1:0] by,
                                        input logic signed [CB-1:0] cx,
                                        input logic signed [CB-1:0] bx);
        logic res;
        if (cs != bs) begin
            res = cs < bs;
        end else if (cy != by) begin
            res = cy < by;
        end else begin
            res = cx < bx;
        end
        return res;
    endfunction

    // stage a: pick the origin, form edges
    logic signed [DW-1:0] sum [3];
    logic                 ll10, ll20, ll21;
    logic [1:0]           so, sf, sg;

    always_comb begin
        for (int s = 0; s < 3; s++) begin
            sum[s] = DW'(i_px[s]) + DW'(i_py[s]);
        end
        ll10 = lower_left(sum[1], sum[0], i_py[1], i_py[0], i_px[1], i_px[0]);
        ll20 = lower_left(sum[2], sum[0], i_py[2], i_py[0], i_px[2], i_px[0]);
        ll21 = lower_left(sum[2], sum[1], i_py[2], i_py[1], i_px[2], i_px[1]);
        if (ll10) begin
            so = ll21 ? 2'd2 : 2'd1;
        end else begin
            so = ll20 ? 2'd2 : 2'd0;
        end
        case (so)
            2'd0:    begin sf = 2'd1; sg = 2'd2; end
            2'd1:    begin sf = 2'd2; sg = 2'd0; end
            default: begin sf = 2'd0; sg = 2'd1; end
        endcase
    end

    logic                 r_a_valid;
    logic [IDX_W-1:0]     r_a_idx [3];
    logic signed [DW-1:0] r_a_m00, r_a_m10, r_a_m01, r_a_m11;
    logic [SIDE_W-1:0]    r_a_side;

    // stage b: products
    logic                 r_b_valid;
    logic [IDX_W-1:0]     r_b_idx [3];
    logic signed [DW-1:0] r_b_m00, r_b_m10, r_b_m01, r_b_m11;
    logic signed [PW-1:0] r_b_p0, r_b_p1;
    logic [SIDE_W-1:0]    r_b_side;

    // stage c: determinant, numerator magnitudes
    logic                   r_c_valid;
    logic [IDX_W-1:0]       r_c_idx [3];
    logic signed [DETW-1:0] r_c_det;
    logic [DW-1:0]          r_c_mag [LANES];
    logic                   r_c_mneg [LANES];
    logic [SIDE_W-1:0]      r_c_side;

    // stage d: clamp
    logic                   r_d_valid;
    logic [IDX_W-1:0]       r_d_idx [3];
    logic [DETW-1:0]        r_d_dmag;
    logic [DW-1:0]          r_d_mag [LANES];
    logic                   r_d_neg [LANES];
    logic [SIDE_W-1:0]      r_d_side;

    logic                   det_neg;
    logic [DETW-1:0]        det_abs, md;

    always_comb begin
        det_neg = r_c_det[DETW-1];
        det_abs = det_neg ? DETW'(-r_c_det) : DETW'(r_c_det);
        md      = (i_min_det == '0) ? DETW'(1) : DETW'(i_min_det);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_valid <= i_ctl.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a_idx[0] <= i_idx[so];
            r_a_idx[1] <= i_idx[sf];
            r_a_idx[2] <= i_idx[sg];
            r_a_m00    <= DW'(i_px[sf]) - DW'(i_px[so]);
            r_a_m10    <= DW'(i_py[sf]) - DW'(i_py[so]);
            r_a_m01    <= DW'(i_px[sg]) - DW'(i_px[so]);
            r_a_m11    <= DW'(i_py[sg]) - DW'(i_py[so]);
            r_a_side   <= i_side;

            r_b_idx  <= r_a_idx;
            r_b_m00  <= r_a_m00;
            r_b_m10  <= r_a_m10;
            r_b_m01  <= r_a_m01;
            r_b_m11  <= r_a_m11;
            r_b_p0   <= r_a_m00 * r_a_m11;
            r_b_p1   <= r_a_m01 * r_a_m10;
            r_b_side <= r_a_side;

            r_c_idx     <= r_b_idx;
            r_c_det     <= DETW'(r_b_p0) - DETW'(r_b_p1);
            // lanes: m11, -m01, -m10, m00
            r_c_mag[0]  <= r_b_m11[DW-1] ? DW'(-r_b_m11) : DW'(r_b_m11);
            r_c_mneg[0] <= r_b_m11[DW-1];
            r_c_mag[1]  <= r_b_m01[DW-1] ? DW'(-r_b_m01) : DW'(r_b_m01);
            r_c_mneg[1] <= ~r_b_m01[DW-1];
            r_c_mag[2]  <= r_b_m10[DW-1] ? DW'(-r_b_m10) : DW'(r_b_m10);
            r_c_mneg[2] <= ~r_b_m10[DW-1];
            r_c_mag[3]  <= r_b_m00[DW-1] ? DW'(-r_b_m00) : DW'(r_b_m00);
            r_c_mneg[3] <= r_b_m00[DW-1];
            r_c_side    <= r_b_side;

            r_d_idx  <= r_c_idx;
            r_d_dmag <= (det_abs < md) ? md : det_abs;
            r_d_mag  <= r_c_mag;
            for (int l = 0; l < LANES; l++) begin
                r_d_neg[l] <= r_c_mneg[l] ^ det_neg;
            end
            r_d_side <= r_c_side;
        end
    end

    assign o_valid   = r_d_valid;
    assign o_idx     = r_d_idx;
    assign o_num_mag = r_d_mag;
    assign o_num_neg = r_d_neg;
    assign o_dmag    = r_d_dmag;
    assign o_side    = r_d_side;

    `RTI_ASSERT(a_dmag_nonzero, r_d_valid |-> (r_d_dmag != '0), "clamped divisor is zero")

endmodule

// ===== rtl/rti_div.sv =====
// four-lane restoring divider, one quotient bit per stage, with sideband
// depends on rti_pkg and rest_triangle_inverse_assert.svh
`include "rest_triangle_inverse_assert.svh"
module rti_div #(
    parameter int CB     = rti_pkg::COORD_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rti_pkg::t_stage_ctl       i_ctl,
    input  logic [CB:0]               i_num_mag [rti_pkg::LANES],
    input  logic                      i_num_neg [rti_pkg::LANES],
    input  logic [2*CB+2:0]           i_dmag,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [rti_pkg::INV_W-1:0] o_quot [rti_pkg::LANES],
    output logic                      o_ovf [rti_pkg::LANES],
    output logic                      o_neg [rti_pkg::LANES],
    output logic [SIDE_W-1:0]         o_side
);
    import rti_pkg::*;

    localparam int DW    = 2 * CB + 3;
    localparam int STEPS = INV_W;
    localparam int HI    = INV_W - Q_SHIFT;

    // r_w holds the low numerator bits still to come; quotient bits shift in below
    logic [DW-1:0]     r_rem [STEPS+1][LANES];
    logic [INV_W-1:0]  r_w   [STEPS+1][LANES];
    logic              r_ovf [STEPS+1][LANES];
    logic              r_neg [STEPS+1][LANES];
    logic [DW-1:0]     r_d   [STEPS+1];
    logic [SIDE_W-1:0] r_side [STEPS+1];
    logic [STEPS:0]    r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[STEPS-1:0], i_ctl.valid};
        end
    end

    // stage 0: overflow check against the top part of the numerator
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d[0]    <= i_dmag;
            r_side[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= DW'(i_num_mag[l] >> HI);
                r_ovf[0][l] <= DW'(i_num_mag[l] >> HI) >= i_dmag;
                r_neg[0][l] <= i_num_neg[l];
                r_w[0][l]   <= INV_W'({i_num_mag[l], {Q_SHIFT{1'b0}}});
            end
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_d[k]    <= r_d[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0] trial;
            logic        ge;
            always_comb begin
                trial = {r_rem[k-1][l], r_w[k-1][l][INV_W-1]};
                ge    = trial >= {1'b0, r_d[k-1]};
            end
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[k][l] <= ge ? DW'(trial - {1'b0, r_d[k-1]}) : DW'(trial);
                    r_w[k][l]   <= {r_w[k-1][l][INV_W-2:0], ge};
                    r_ovf[k][l] <= r_ovf[k-1][l];
                    r_neg[k][l] <= r_neg[k-1][l];
                end
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_quot  = r_w[STEPS];
    assign o_ovf   = r_ovf[STEPS];
    assign o_neg   = r_neg[STEPS];
    assign o_side  = r_side[STEPS];

    // flags for lanes 0 and 3 when their quotient fitted in 32 bits, the only case with a bounded remainder
    logic fit0, fit3;

    assign fit0 = r_valid[STEPS] && !r_ovf[STEPS][0];
    assign fit3 = r_valid[STEPS] && !r_ovf[STEPS][3];

    `RTI_ASSERT(a_rem_lane0, fit0 |-> (r_rem[STEPS][0] < r_d[STEPS]), "remainder too large")
    `RTI_ASSERT(a_rem_lane3, fit3 |-> (r_rem[STEPS][3] < r_d[STEPS]), "remainder too large")
    `RTI_ASSERT_NEXT(a_stall_holds, !i_ctl.en, $stable(r_valid), "valid bits moved during stall")

endmodule

// ===== rtl/rest_triangle_inverse.sv =====
// a result passes the front end (4 stages), the divider (33) and the output register (1);
// throughput one triangle per cycle while the output is not stalled
// a stall at the output freezes the whole pipeline, nothing is lost or repeated
// reset (synchronous, active low) clears every valid bit and loads the register defaults
// depends on rti_pkg, rti_front, rti_div and rest_triangle_inverse_assert.svh
`include "rest_triangle_inverse_assert.svh"
module rest_triangle_inverse #(
    parameter int VERTEX_INDEX_BITS = rti_pkg::VERTEX_INDEX_BITS_DEF,
    parameter int COORD_BITS        = rti_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transfer
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [VERTEX_INDEX_BITS-1:0]        i_vert_index_a,
    input  logic [VERTEX_INDEX_BITS-1:0]        i_vert_index_b,
    input  logic [VERTEX_INDEX_BITS-1:0]        i_vert_index_c,
    input  logic signed [COORD_BITS-1:0]        i_pos_ax,
    input  logic signed [COORD_BITS-1:0]        i_pos_ay,
    input  logic signed [COORD_BITS-1:0]        i_pos_bx,
    input  logic signed [COORD_BITS-1:0]        i_pos_by,
    input  logic signed [COORD_BITS-1:0]        i_pos_cx,
    input  logic signed [COORD_BITS-1:0]        i_pos_cy,
    input  logic signed [rti_pkg::MAT_IN_W-1:0] i_material_in,
    input  logic                                i_material_present,
    // result transfer
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [VERTEX_INDEX_BITS-1:0]        o_origin_index,
    output logic [VERTEX_INDEX_BITS-1:0]        o_first_index,
    output logic [VERTEX_INDEX_BITS-1:0]        o_second_index,
    output logic signed [rti_pkg::INV_W-1:0]    o_inv_00,
    output logic signed [rti_pkg::INV_W-1:0]    o_inv_01,
    output logic signed [rti_pkg::INV_W-1:0]    o_inv_10,
    output logic signed [rti_pkg::INV_W-1:0]    o_inv_11,
    output logic [2*COORD_BITS+1:0]             o_area_out,
    output logic [rti_pkg::MAT_OUT_W-1:0]       o_material_out,
    output logic                                o_material_valid,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rti_pkg::*;

    localparam int IW     = VERTEX_INDEX_BITS;
    localparam int CB     = COORD_BITS;
    localparam int DW     = 2 * CB + 3;
    localparam int AW     = 2 * CB + 2;
    localparam int MSIDE  = MAT_OUT_W + 1;
    localparam int DSIDE  = 3 * IW + AW + MSIDE;

    // configuration registers
    logic [MIN_DET_W-1:0] r_min_det;
    logic [MAT_OUT_W-1:0] r_fallback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_det  <= MIN_DET_RST;
            r_fallback <= FALLBACK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_DET:      r_min_det  <= MIN_DET_W'(i_cfg_data);
                CFG_FALLBACK_MAT: r_fallback <= MAT_OUT_W'(i_cfg_data);
                default:          ;
            endcase
        end
    end

    // one advance enable for the whole pipe: moves whenever the output register is free
    logic       en;
    t_stage_ctl front_ctl, div_ctl;
    logic       r_out_valid;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign front_ctl  = '{en: en, valid: i_in_valid};

    // material: absent gives zero, not positive gives the fallback
    logic                 mat_pos;
    logic [MAT_OUT_W-1:0] mat_val;
    logic [MSIDE-1:0]     mat_side;

    always_comb begin
        mat_pos = !i_material_in[MAT_IN_W-1] && (i_material_in != '0);
        if (!i_material_present) begin
            mat_val = '0;
        end else if (mat_pos) begin
            mat_val = MAT_OUT_W'(i_material_in);
        end else begin
            mat_val = r_fallback;
        end
        mat_side = {mat_val, i_material_present};
    end

    logic [IW-1:0]        in_idx [3];
    logic signed [CB-1:0] in_px [3];
    logic signed [CB-1:0] in_py [3];

    assign in_idx = '{i_vert_index_a, i_vert_index_b, i_vert_index_c};
    assign in_px  = '{i_pos_ax, i_pos_bx, i_pos_cx};
    assign in_py  = '{i_pos_ay, i_pos_by, i_pos_cy};

    // front end: origin pick, edge matrix, determinant clamp
    logic             f_valid;
    logic [IW-1:0]    f_idx [3];
    logic [CB:0]      f_mag [LANES];
    logic             f_neg [LANES];
    logic [DW-1:0]    f_dmag;
    logic [MSIDE-1:0] f_side;

    rti_front #(
        .IDX_W  (IW),
        .CB     (CB),
        .SIDE_W (MSIDE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (front_ctl),
        .i_idx     (in_idx),
        .i_px      (in_px),
        .i_py      (in_py),
        .i_min_det (r_min_det),
        .i_side    (mat_side),
        .o_valid   (f_valid),
        .o_idx     (f_idx),
        .o_num_mag (f_mag),
        .o_num_neg (f_neg),
        .o_dmag    (f_dmag),
        .o_side    (f_side)
    );

    // indices, area and material ride along with the divider
    logic [DSIDE-1:0] d_side_in, d_side_out;

    assign div_ctl   = '{en: en, valid: f_valid};
    assign d_side_in = {f_idx[0], f_idx[1], f_idx[2], AW'(f_dmag >> 1), f_side};

    logic             d_valid;
    logic [INV_W-1:0] d_quot [LANES];
    logic             d_ovf [LANES];
    logic             d_neg [LANES];

    rti_div #(
        .CB     (CB),
        .SIDE_W (DSIDE)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (div_ctl),
        .i_num_mag (f_mag),
        .i_num_neg (f_neg),
        .i_dmag    (f_dmag),
        .i_side    (d_side_in),
        .o_valid   (d_valid),
        .o_quot    (d_quot),
        .o_ovf     (d_ovf),
        .o_neg     (d_neg),
        .o_side    (d_side_out)
    );

    // saturate to q4.28 and apply the sign
    function automatic logic [INV_W-1:0] sat_entry(input logic [INV_W-1:0] q,
                                                   input logic             ovf,
                                                   input logic             neg);
        logic [INV_W-1:0] res;
        if (neg) begin
            if (ovf || (q[INV_W-1] && (q[INV_W-2:0] != '0))) begin
                res = {1'b1, {(INV_W-1){1'b0}}};
            end else begin
                res = INV_W'(-q);
            end
        end else begin
            if (ovf || q[INV_W-1]) begin
                res = {1'b0, {(INV_W-1){1'b1}}};
            end else begin
                res = q;
            end
        end
        return res;
    endfunction

    // output register
    logic [IW-1:0]        r_origin, r_first, r_second;
    logic [INV_W-1:0]     r_inv [LANES];
    logic [AW-1:0]        r_area;
    logic [MAT_OUT_W-1:0] r_mat;
    logic                 r_mat_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_origin, r_first, r_second, r_area, r_mat, r_mat_valid} <= d_side_out;
            for (int l = 0; l < LANES; l++) begin
                r_inv[l] <= sat_entry(d_quot[l], d_ovf[l], d_neg[l]);
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_origin_index   = r_origin;
    assign o_first_index    = r_first;
    assign o_second_index   = r_second;
    assign o_inv_00         = r_inv[0];
    assign o_inv_01         = r_inv[1];
    assign o_inv_10         = r_inv[2];
    assign o_inv_11         = r_inv[3];
    assign o_area_out       = r_area;
    assign o_material_out   = r_mat;
    assign o_material_valid = r_mat_valid;

    `RTI_ASSERT(a_mat_absent_zero, (r_out_valid && !r_mat_valid) |-> (r_mat == '0), "mat not zero")

endmodule
